/* design/ir_pulse_width_decoder_macros.svh */
// Assertion helpers for the checker file of the IR pulse decoder.
`ifndef IR_PULSE_WIDTH_DECODER_MACROS_SVH
`define IR_PULSE_WIDTH_DECODER_MACROS_SVH

// Check that holds only out of reset.
`define IRPWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that must also hold while reset is applied.
`define IRPWD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/irpwd_pkg.sv */
package irpwd_pkg;

  localparam int unsigned WIDTH_W   = 8;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned CFG_IDX_W = 3;

  // Default frame length in bits
  localparam int unsigned FRAME_BITS_DEF = 32;

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MIN  = 3'd0,
    REG_ABORT_WIDTH = 3'd1,
    REG_ONE_MIN     = 3'd2,
    REG_ONE_MAX     = 3'd3,
    REG_ZERO_MIN    = 3'd4,
    REG_ZERO_MAX    = 3'd5
  } cfg_reg_t;

  // Reset values of the band thresholds
  localparam width_t LEADER_MIN_RST  = 8'd200;
  localparam width_t ABORT_WIDTH_RST = 8'd250;
  localparam width_t ONE_MIN_RST     = 8'd60;
  localparam width_t ONE_MAX_RST     = 8'd90;
  localparam width_t ZERO_MIN_RST    = 8'd10;
  localparam width_t ZERO_MAX_RST    = 8'd50;

  // Pulse counter saturates here
  localparam count_t COUNT_MAX = '1;

endpackage

/* design/ir_pulse_width_decoder.sv */
// IR remote frame decoder working on measured high-pulse widths.
// in_*  : one pulse width (timer ticks) per request on in_tdata[7:0].
// out_* : one decoded frame per request; out_tdata[31:0] is the code register,
//         out_tuser[0] is 1 for a full frame and 0 for an aborted frame.
// cfg_* : register writes (index, 8-bit data), always ready; write only when
//         the block is idle.
// A pulse in the leader band arms the decoder; that pulse and each later one
// below the abort width shift one bit into the code. A pulse that ends a
// frame is held in the input register while the decode logic feeds its
// result into the output register. Pulses that end no frame give no result.
// Throughput is one pulse per cycle; the only limit is the output register,
// which holds a result until it is taken. While the receiver stalls, one
// more pulse can sit in the input register; it waits there only if it would
// produce a result, so in_tready drops once both registers are full.
// Reset (rst_n low, synchronous) restores the default thresholds, clears the
// code, the last bit, the pulse counter and the leader flag, and empties both
// registers.
module ir_pulse_width_decoder #(
  parameter int unsigned FRAME_BITS = irpwd_pkg::FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input pulses
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] high_width
  // decoded frames
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] code_word
  output logic [0:0]  out_tuser,  // [0] complete
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // threshold registers
  irpwd_pkg::width_t leader_min_r, abort_width_r, one_min_r, one_max_r;
  irpwd_pkg::width_t zero_min_r, zero_max_r;

  // decoder state
  logic              leader_seen_r, leader_seen_nxt;
  irpwd_pkg::code_t  code_shift_r, code_shift_nxt;
  irpwd_pkg::count_t pulse_count_r, pulse_count_nxt;
  logic              last_bit_r, last_bit_nxt;

  // input register
  logic              in_valid_r;
  irpwd_pkg::width_t in_width_r;

  // output register
  logic              out_valid_r;
  irpwd_pkg::code_t  out_code_r;
  logic              out_complete_r;

  // decode results
  logic             res_valid;
  irpwd_pkg::code_t res_code;
  logic             res_complete;
  logic             out_free;
  logic             fire;

  assign cfg_ready = 1'b1;

  // configuration writes; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_min_r  <= irpwd_pkg::LEADER_MIN_RST;
      abort_width_r <= irpwd_pkg::ABORT_WIDTH_RST;
      one_min_r     <= irpwd_pkg::ONE_MIN_RST;
      one_max_r     <= irpwd_pkg::ONE_MAX_RST;
      zero_min_r    <= irpwd_pkg::ZERO_MIN_RST;
      zero_max_r    <= irpwd_pkg::ZERO_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        irpwd_pkg::REG_LEADER_MIN:  leader_min_r  <= cfg_data;
        irpwd_pkg::REG_ABORT_WIDTH: abort_width_r <= cfg_data;
        irpwd_pkg::REG_ONE_MIN:     one_min_r     <= cfg_data;
        irpwd_pkg::REG_ONE_MAX:     one_max_r     <= cfg_data;
        irpwd_pkg::REG_ZERO_MIN:    zero_min_r    <= cfg_data;
        irpwd_pkg::REG_ZERO_MAX:    zero_max_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // band decode and next state for the pulse in the input register
  always_comb begin
    leader_seen_nxt = leader_seen_r;
    code_shift_nxt  = code_shift_r;
    pulse_count_nxt = pulse_count_r;
    last_bit_nxt    = last_bit_r;
    res_valid       = 1'b0;
    res_code        = code_shift_r;
    res_complete    = 1'b0;
    if (in_width_r >= abort_width_r) begin
      // over-long pulse: give out what we have and start over
      res_valid       = 1'b1;
      leader_seen_nxt = 1'b0;
      pulse_count_nxt = '0;
    end else begin
      if (in_width_r >= leader_min_r) begin
        leader_seen_nxt = 1'b1;
      end else if (in_width_r >= one_min_r && in_width_r < one_max_r) begin
        last_bit_nxt = 1'b1;
      end else if (in_width_r >= zero_min_r && in_width_r < zero_max_r) begin
        last_bit_nxt = 1'b0;
      end
      if (leader_seen_nxt) begin
        code_shift_nxt = {code_shift_r[irpwd_pkg::CODE_W-2:0], last_bit_nxt};
      end
      if (leader_seen_nxt && pulse_count_r >= irpwd_pkg::count_t'(FRAME_BITS)) begin
        // frame full
        res_valid       = 1'b1;
        res_code        = code_shift_nxt;
        res_complete    = 1'b1;
        leader_seen_nxt = 1'b0;
        pulse_count_nxt = '0;
      end else if (pulse_count_r != irpwd_pkg::COUNT_MAX) begin
        pulse_count_nxt = pulse_count_r + irpwd_pkg::count_t'(1);
      end
    end
  end

  // a pulse leaves the input register unless its result has nowhere to go
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (!res_valid || out_free);
  assign in_tready = !in_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_width_r <= in_tdata;
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_seen_r <= 1'b0;
      code_shift_r  <= '0;
      pulse_count_r <= '0;
      last_bit_r    <= 1'b0;
    end else if (fire) begin
      leader_seen_r <= leader_seen_nxt;
      code_shift_r  <= code_shift_nxt;
      pulse_count_r <= pulse_count_nxt;
      last_bit_r    <= last_bit_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_code_r     <= res_code;
      out_complete_r <= res_complete;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_code_r;
  assign out_tuser[0] = out_complete_r;

endmodule

/* design/irpwd_checker.sv */
`include "ir_pulse_width_decoder_macros.svh"

// Port-level checks for the IR pulse decoder.
module irpwd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result keeps its payload
  `IRPWD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "out: stalled result changed")

  // a waiting request keeps its payload
  `IRPWD_ASSERT(a_in_hold, in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata), "in: waiting request changed")

  // reset empties the output register
  `IRPWD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "out: valid after reset")

  // the input side never stalls while the output register can take a result
  `IRPWD_ASSERT(a_in_ready, !out_tvalid || out_tready |-> in_tready, "in: stalled with free output")

  // configuration writes are never refused
  `IRPWD_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "cfg: write refused")

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FRAME_LEN = irpwd_pkg::FRAME_BITS_DEF;

  // Indexes past the last threshold register; writes there change nothing
  localparam logic [irpwd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [irpwd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    irpwd_pkg::code_t code_word;
    logic             complete;
  } frame_result_t;

  // Decoder model plus the queue of frames it has announced
  class frame_scoreboard;
    irpwd_pkg::width_t leader_min, abort_width, one_min, one_max, zero_min, zero_max;
    logic              leader_seen;
    irpwd_pkg::code_t  code_shift;
    irpwd_pkg::count_t pulse_count;
    logic              last_bit;
    frame_result_t     pending_frames[$];
    int                errors;

    function new();
      leader_min  = irpwd_pkg::LEADER_MIN_RST;
      abort_width = irpwd_pkg::ABORT_WIDTH_RST;
      one_min     = irpwd_pkg::ONE_MIN_RST;
      one_max     = irpwd_pkg::ONE_MAX_RST;
      zero_min    = irpwd_pkg::ZERO_MIN_RST;
      zero_max    = irpwd_pkg::ZERO_MAX_RST;
      leader_seen = 1'b0;
      code_shift  = '0;
      pulse_count = '0;
      last_bit    = 1'b0;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(logic [irpwd_pkg::CFG_IDX_W-1:0] idx, irpwd_pkg::width_t val);
      case (idx)
        irpwd_pkg::REG_LEADER_MIN:  leader_min  = val;
        irpwd_pkg::REG_ABORT_WIDTH: abort_width = val;
        irpwd_pkg::REG_ONE_MIN:     one_min     = val;
        irpwd_pkg::REG_ONE_MAX:     one_max     = val;
        irpwd_pkg::REG_ZERO_MIN:    zero_min    = val;
        irpwd_pkg::REG_ZERO_MAX:    zero_max    = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    function void push_frame(logic done);
      frame_result_t fr;
      fr.code_word = code_shift;
      fr.complete  = done;
      pending_frames.push_back(fr);
      leader_seen = 1'b0;
      pulse_count = '0;
    endfunction

    // Apply one accepted pulse width to the model
    function void note_pulse(irpwd_pkg::width_t w);
      // over-long pulse aborts regardless of state
      if (w >= abort_width) begin
        push_frame(1'b0);
        return;
      end
      // band priority: leader, one, zero; leader never touches last_bit
      if (w >= leader_min)
        leader_seen = 1'b1;
      else if (w >= one_min && w < one_max)
        last_bit = 1'b1;
      else if (w >= zero_min && w < zero_max)
        last_bit = 1'b0;
      if (leader_seen) begin
        code_shift = {code_shift[irpwd_pkg::CODE_W-2:0], last_bit};
        if (int'(pulse_count) >= FRAME_LEN) begin
          push_frame(1'b1);
          return;
        end
      end
      if (pulse_count != irpwd_pkg::COUNT_MAX)
        pulse_count++;
    endfunction

    task check_frame(irpwd_pkg::code_t code, logic done);
      frame_result_t fr;
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected frame code=%08h complete=%0b", code, done));
        return;
      end
      fr = pending_frames.pop_front();
      if (code !== fr.code_word)
        report($sformatf("code_word %08h, expected %08h", code, fr.code_word));
      if (done !== fr.complete)
        report($sformatf("complete %0b, expected %0b", done, fr.complete));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] high_width
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] code_word
  logic [0:0]  out_tuser;   // [0] complete
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  frame_scoreboard sb = new();
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ir_pulse_width_decoder #(.FRAME_BITS(FRAME_LEN)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Frame checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_frame(out_tdata, out_tuser[0]);
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    int hold_left;
    int idle_left;
    hold_left  = 0;
    idle_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_left == 0) begin
        long_hold_req = 1'b0;
        hold_left     = 400;
      end
      if (!rst_n) begin
        out_tready = 1'b0;
      end else if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_tready = 1'b0;
        idle_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        idle_left  = $urandom_range(1, 16) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Run watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // One pulse request; entered and left at a falling edge
  task automatic send_pulse(input irpwd_pkg::width_t w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = w;
    do @(posedge clk); while (!in_tready);
    sb.note_pulse(w);
    @(negedge clk);
  endtask

  // One register write; cfg_valid is left high for the caller to drop
  task automatic write_reg(input logic [irpwd_pkg::CFG_IDX_W-1:0] idx,
                           input irpwd_pkg::width_t val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_thresholds(input irpwd_pkg::width_t lead,
                                    input irpwd_pkg::width_t abrt,
                                    input irpwd_pkg::width_t omin,
                                    input irpwd_pkg::width_t omax,
                                    input irpwd_pkg::width_t zmin,
                                    input irpwd_pkg::width_t zmax,
                                    input bit spare);
    write_reg(irpwd_pkg::REG_LEADER_MIN, lead);
    write_reg(irpwd_pkg::REG_ABORT_WIDTH, abrt);
    write_reg(irpwd_pkg::REG_ONE_MIN, omin);
    write_reg(irpwd_pkg::REG_ONE_MAX, omax);
    write_reg(irpwd_pkg::REG_ZERO_MIN, zmin);
    write_reg(irpwd_pkg::REG_ZERO_MAX, zmax);
    if (spare) begin
      write_reg(REG_SPARE_LO, irpwd_pkg::width_t'($urandom_range(0, 255)));
      write_reg(REG_SPARE_HI, irpwd_pkg::width_t'($urandom_range(0, 255)));
    end
    cfg_valid = 1'b0;
  endtask

  // Quiesce before touching the thresholds
  task automatic wait_idle();
    int guard;
    guard     = 0;
    in_tvalid = 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (6) @(negedge clk);
  endtask

  function automatic irpwd_pkg::width_t pick_band(int lo, int hi);
    if (lo < hi)
      return irpwd_pkg::width_t'($urandom_range(hi - 1, lo));
    return irpwd_pkg::width_t'($urandom_range(0, 255));
  endfunction

  function automatic irpwd_pkg::width_t bit_pulse();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9)
      return pick_band(sb.one_min, sb.one_max);
    else if (r < 18)
      return pick_band(sb.zero_min, sb.zero_max);
    return irpwd_pkg::width_t'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed frames under the current thresholds, some noise
  task automatic run_pulses(input int n_items);
    int sent;
    int kind;
    int nbits;
    int pre;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_pulse(irpwd_pkg::width_t'($urandom_range(0, 255)));
        sent++;
      end else if (kind == 1) begin
        // broken frame: leader, a few bits, then an over-long pulse
        send_pulse(pick_band(sb.leader_min, sb.abort_width));
        nbits = $urandom_range(0, 12);
        repeat (nbits) send_pulse(bit_pulse());
        send_pulse(irpwd_pkg::width_t'($urandom_range(255, sb.abort_width)));
        sent += nbits + 2;
      end else begin
        pre = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (pre) send_pulse(bit_pulse());
        send_pulse(pick_band(sb.leader_min, sb.abort_width));
        nbits = $urandom_range(30, 40);
        repeat (nbits) send_pulse(bit_pulse());
        sent += pre + nbits + 1;
      end
    end
  endtask

  // Main sequence
  initial begin
    irpwd_pkg::width_t directed[$];
    int guard;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // band edges at reset thresholds, then leader, shift, leader, two aborts
    directed = '{8'd0, 8'd9, 8'd10, 8'd49, 8'd50, 8'd59, 8'd60, 8'd89, 8'd90,
                 8'd199, 8'd200, 8'd75, 8'd249, 8'd250, 8'd255};
    foreach (directed[i]) send_pulse(directed[i]);
    run_pulses(200);

    // everything aborts; receiver holds off so the block backs up
    wait_idle();
    program_thresholds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    long_hold_req = 1'b1;
    run_pulses(200);

    // all thresholds at the top: only 255 aborts, no leader possible
    wait_idle();
    program_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    run_pulses(200);

    // overlapping bands
    wait_idle();
    program_thresholds(8'd100, 8'd200, 8'd40, 8'd120, 8'd30, 8'd70, 1'b0);
    run_pulses(220);

    // random thresholds
    repeat (3) begin
      wait_idle();
      program_thresholds(irpwd_pkg::width_t'($urandom_range(0, 255)),
                         irpwd_pkg::width_t'($urandom_range(0, 255)),
                         irpwd_pkg::width_t'($urandom_range(0, 255)),
                         irpwd_pkg::width_t'($urandom_range(0, 255)),
                         irpwd_pkg::width_t'($urandom_range(0, 255)),
                         irpwd_pkg::width_t'($urandom_range(0, 255)),
                         1'b1);
      run_pulses(160);
    end

    // back to defaults, at full rate on both sides
    wait_idle();
    program_thresholds(irpwd_pkg::LEADER_MIN_RST, irpwd_pkg::ABORT_WIDTH_RST,
                       irpwd_pkg::ONE_MIN_RST, irpwd_pkg::ONE_MAX_RST,
                       irpwd_pkg::ZERO_MIN_RST, irpwd_pkg::ZERO_MAX_RST, 1'b0);
    quiet = 1'b1;
    run_pulses(250);
    in_tvalid = 1'b0;

    // drain
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected frames never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* ir_pulse_width_decoder.f */
+incdir+design
design/irpwd_pkg.sv
design/ir_pulse_width_decoder.sv
design/irpwd_checker.sv
bench/testbench.sv
